@@ rtl/nfha_pkg.sv @@
// Shared types and constants for the next-fit heap allocator.
package nfha_pkg;

   localparam int STATUS_W   = 2;
   localparam int BYTES_W    = 20;
   localparam int ADDR_W     = 16;
   localparam int FREE_W     = 17;
   localparam int UNITS_W    = 13;
   localparam int NEED_W     = 17;
   localparam int UNIT_SHIFT = 4;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_HEAP = 2'd2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic REG_HEAP_BASE  = 1'b0;
   localparam logic REG_HEAP_UNITS = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_START,
      ST_A_ROV,
      ST_A_ROVD,
      ST_A_WALK,
      ST_A_SPLIT,
      ST_F_ONE,
      ST_F_ONED,
      ST_F_ROV,
      ST_F_WALK,
      ST_F_RDB,
      ST_F_RDU,
      ST_F_WRP,
      ST_DONE
   } state_type;

endpackage

@@ rtl/nfha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module nfha_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/next_fit_heap_allocator_top.sv @@
// Next-fit heap allocator: sequencer around one header RAM.
// Allocate: starts the heap on first use, reads the rover, walks the list, splits a larger block;
// free: walks the list, reads block and upper neighbour, writes predecessor; rejects go to done.
// Throughput: one word in flight; the list walk does one header RAM read per cycle.
// A finished result waits in an output register while the next word is taken.
// Reset: synchronous; clears control state only, the header RAM needs no clearing pass.
module next_fit_heap_allocator_top import nfha_pkg::*; #(
   parameter int HEAP_UNITS = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [BYTES_W-1:0]  req_request_bytes,
   input  logic [ADDR_W-1:0]   req_block_address,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_granted_address,
   output logic [FREE_W-1:0]   rsp_free_bytes,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int IW = $clog2(HEAP_UNITS);
   localparam int SW = $clog2(HEAP_UNITS + 1);
   localparam int CW = $clog2(HEAP_UNITS + 1);
   localparam int HW = SW + IW;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [UNITS_W-1:0]  units_ff, units_in;
   logic [IW-1:0]       rover_ff, rover_in;
   logic                started_ff, started_in;
   logic                empty_ff, empty_in;
   logic [SW-1:0]       count_ff, count_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [IW-1:0]       bp_ff, bp_in;
   logic [IW-1:0]       p_ff, p_in;
   logic [IW-1:0]       prev_ff, prev_in;
   logic [SW-1:0]       prev_size_ff, prev_size_in;
   logic [IW-1:0]       up_ff, up_in;
   logic [SW-1:0]       size_b_ff, size_b_in;
   logic [SW-1:0]       newb_size_ff, newb_size_in;
   logic [IW-1:0]       newb_next_ff, newb_next_in;
   logic [IW-1:0]       blk_ff, blk_in;
   logic [CW-1:0]       steps_ff, steps_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ADDR_W-1:0]   res_granted_ff, res_granted_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_granted_ff, rsp_granted_in;
   logic [FREE_W-1:0]   rsp_free_ff, rsp_free_in;

   logic          ram_we;
   logic [IW-1:0] ram_wr_addr;
   logic [HW-1:0] ram_wr_data;
   logic [IW-1:0] ram_rd_addr;
   logic [HW-1:0] ram_rd_data;

   logic [SW-1:0]     eff;
   logic [SW-1:0]     rd_size;
   logic [IW-1:0]     rd_next;
   logic              accept;
   logic              csr_write;
   logic [ADDR_W-1:0] bp_full;
   logic              bp_outside;
   logic [NEED_W-1:0] need_req;
   logic              fit;
   logic              exact;
   logic              last_step;
   logic              found;
   logic [SW:0]       add_sum;
   logic [SW-1:0]     add_arg;
   logic [SW-1:0]     count_added;
   logic [SW-1:0]     split_size;
   logic              merge_up;
   logic              merge_dn;
   logic              out_free;

   nfha_ram #(.WIDTH(HW), .DEPTH(HEAP_UNITS)) u_hdr_ram (
      .clock   (clock),
      .we      (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign eff = (32'(units_ff) > HEAP_UNITS) ? SW'(HEAP_UNITS) : SW'(units_ff);
   assign rd_size = ram_rd_data[HW-1:IW];
   assign rd_next = ram_rd_data[IW-1:0];
   assign accept = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign bp_full = req_block_address - base_ff - 16'd1;
   assign bp_outside = 32'(bp_full) >= 32'(eff);
   assign need_req = NEED_W'((32'(req_request_bytes) + 32'd15) >> UNIT_SHIFT) + NEED_W'(1);
   assign fit = 32'(rd_size) >= 32'(need_ff);
   assign exact = 32'(rd_size) == 32'(need_ff);
   assign last_step = steps_ff == CW'(HEAP_UNITS);
   assign found = (bp_ff > p_ff && bp_ff < rd_next) ||
                  (p_ff >= rd_next && (bp_ff > p_ff || bp_ff < rd_next));
   assign add_arg = (state_ff == ST_F_ONED || state_ff == ST_F_RDB) ? rd_size : '0;
   assign add_sum = (SW+1)'(count_ff) + (SW+1)'(add_arg);
   assign count_added = (32'(add_sum) > 32'(eff)) ? eff : SW'(add_sum);
   assign split_size = SW'(32'(rd_size) - 32'(need_ff));
   assign merge_up = (32'(bp_ff) + 32'(size_b_ff)) == 32'(up_ff);
   assign merge_dn = (32'(p_ff) + 32'(prev_size_ff)) == 32'(bp_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_free_bytes = rsp_free_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_HEAP_UNITS) ? 32'(units_ff) : 32'(base_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_ALLOC) begin
                  if (!started_ff)    state_in = ST_A_START;
                  else if (empty_ff)  state_in = ST_DONE;
                  else                state_in = ST_A_ROV;
               end else begin
                  if (!started_ff || bp_outside) state_in = ST_DONE;
                  else if (empty_ff)             state_in = ST_F_ONE;
                  else                           state_in = ST_F_ROV;
               end
            end
         end
         ST_A_START: state_in = (eff == '0) ? ST_DONE : ST_A_ROV;
         ST_A_ROV:   state_in = ST_A_ROVD;
         ST_A_ROVD:  state_in = ST_A_WALK;
         ST_A_WALK: begin
            if (fit)                                state_in = exact ? ST_DONE : ST_A_SPLIT;
            else if (p_ff == rover_ff || last_step) state_in = ST_DONE;
         end
         ST_A_SPLIT: state_in = ST_DONE;
         ST_F_ONE:   state_in = ST_F_ONED;
         ST_F_ONED:  state_in = ST_DONE;
         ST_F_ROV:   state_in = ST_F_WALK;
         ST_F_WALK: begin
            if (found)          state_in = ST_F_RDB;
            else if (last_step) state_in = ST_DONE;
         end
         ST_F_RDB: state_in = ST_F_RDU;
         ST_F_RDU: state_in = ST_F_WRP;
         ST_F_WRP: state_in = ST_DONE;
         ST_DONE:  state_in = out_free ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      base_in = base_ff;
      units_in = units_ff;
      rover_in = rover_ff;
      started_in = started_ff;
      empty_in = empty_ff;
      count_in = count_ff;
      need_in = need_ff;
      bp_in = bp_ff;
      p_in = p_ff;
      prev_in = prev_ff;
      prev_size_in = prev_size_ff;
      up_in = up_ff;
      size_b_in = size_b_ff;
      newb_size_in = newb_size_ff;
      newb_next_in = newb_next_ff;
      blk_in = blk_ff;
      steps_in = steps_ff;
      res_status_in = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_free_in = rsp_free_ff;
      ram_we = 1'b0;
      ram_wr_addr = p_ff;
      ram_wr_data = '0;
      ram_rd_addr = p_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               need_in = need_req;
               bp_in = IW'(bp_full);
               steps_in = '0;
               res_granted_in = '0;
               res_status_in = STATUS_OK;
               if (req_kind == KIND_ALLOC && started_ff && empty_ff) begin
                  res_status_in = STATUS_NO_FIT;
               end
               if (req_kind == KIND_FREE && !started_ff) begin
                  res_status_in = STATUS_NO_HEAP;
               end
            end
         end
         ST_A_START: begin
            ram_we = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = {eff, IW'(0)};
            rover_in = '0;
            count_in = eff;
            started_in = 1'b1;
            empty_in = eff == '0;
            if (eff == '0) begin
               res_status_in = STATUS_NO_FIT;
            end
         end
         ST_A_ROV: ram_rd_addr = rover_ff;
         ST_A_ROVD: begin
            prev_in = rover_ff;
            prev_size_in = rd_size;
            p_in = rd_next;
            ram_rd_addr = rd_next;
         end
         ST_A_WALK: begin
            if (fit) begin
               ram_we = 1'b1;
               if (exact) begin
                  ram_wr_addr = prev_ff;
                  ram_wr_data = {prev_size_ff, rd_next};
                  if (p_ff == prev_ff) begin
                     empty_in = 1'b1;
                  end
                  blk_in = p_ff;
                  res_granted_in = ADDR_W'(32'(base_ff) + 32'(p_ff) + 32'd1);
               end else begin
                  ram_wr_addr = p_ff;
                  ram_wr_data = {split_size, rd_next};
                  blk_in = IW'(32'(p_ff) + 32'(split_size));
                  newb_next_in = rd_next;
                  res_granted_in = ADDR_W'(32'(base_ff) +
                                   32'(IW'(32'(p_ff) + 32'(split_size))) + 32'd1);
               end
               rover_in = prev_ff;
               count_in = (32'(count_ff) >= 32'(need_ff)) ? SW'(32'(count_ff) - 32'(need_ff))
                                                         : '0;
               res_status_in = STATUS_OK;
            end else if (p_ff == rover_ff || last_step) begin
               res_status_in = STATUS_NO_FIT;
            end else begin
               prev_in = p_ff;
               prev_size_in = rd_size;
               p_in = rd_next;
               ram_rd_addr = rd_next;
               steps_in = steps_ff + CW'(1);
            end
         end
         ST_A_SPLIT: begin
            ram_we = 1'b1;
            ram_wr_addr = blk_ff;
            ram_wr_data = {SW'(need_ff), newb_next_ff};
         end
         ST_F_ONE: ram_rd_addr = bp_ff;
         ST_F_ONED: begin
            ram_we = 1'b1;
            ram_wr_addr = bp_ff;
            ram_wr_data = {rd_size, bp_ff};
            rover_in = bp_ff;
            empty_in = 1'b0;
            count_in = count_added;
         end
         ST_F_ROV: begin
            ram_rd_addr = rover_ff;
            p_in = rover_ff;
         end
         ST_F_WALK: begin
            if (found) begin
               prev_size_in = rd_size;
               up_in = rd_next;
               ram_rd_addr = bp_ff;
            end else if (!last_step) begin
               p_in = rd_next;
               ram_rd_addr = rd_next;
               steps_in = steps_ff + CW'(1);
            end
         end
         ST_F_RDB: begin
            size_b_in = rd_size;
            count_in = count_added;
            ram_rd_addr = up_ff;
         end
         ST_F_RDU: begin
            newb_size_in = merge_up ? SW'(size_b_ff + rd_size) : size_b_ff;
            newb_next_in = merge_up ? rd_next : up_ff;
            ram_we = 1'b1;
            ram_wr_addr = bp_ff;
            ram_wr_data = {newb_size_in, newb_next_in};
         end
         ST_F_WRP: begin
            ram_we = 1'b1;
            ram_wr_addr = p_ff;
            ram_wr_data = merge_dn ? {SW'(prev_size_ff + newb_size_ff), newb_next_ff}
                                   : {prev_size_ff, bp_ff};
            rover_in = p_ff;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_granted_in = res_granted_ff;
               rsp_free_in = FREE_W'(32'(count_ff) << UNIT_SHIFT);
            end
         end
         default: ;
      endcase
      if (csr_write) begin
         if (csr_paddr[2] == REG_HEAP_BASE) begin
            base_in = csr_pwdata[ADDR_W-1:0];
         end else begin
            units_in = csr_pwdata[UNITS_W-1:0];
         end
         started_in = 1'b0;
         empty_in = 1'b0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_ff <= '0;
         units_ff <= UNITS_W'(4096);
         rover_ff <= '0;
         started_ff <= 1'b0;
         empty_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         units_ff <= units_in;
         rover_ff <= rover_in;
         started_ff <= started_in;
         empty_ff <= empty_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff <= need_in;
      bp_ff <= bp_in;
      p_ff <= p_in;
      prev_ff <= prev_in;
      prev_size_ff <= prev_size_in;
      up_ff <= up_in;
      size_b_ff <= size_b_in;
      newb_size_ff <= newb_size_in;
      newb_next_ff <= newb_next_in;
      blk_ff <= blk_in;
      steps_ff <= steps_in;
      res_status_ff <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_status_ff <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_free_ff <= rsp_free_in;
   end

endmodule

@@ rtl/nfha_checker.sv @@
// Port-level checks for the next-fit heap allocator, bound to the top level.
module nfha_checker import nfha_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ADDR_W-1:0]   rsp_granted_address,
   input logic [FREE_W-1:0]   rsp_free_bytes
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response word dropped or changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_NO_FIT ||
                    rsp_status == STATUS_NO_HEAP)
      else $error("undefined status code");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_granted_address == '0)
      else $error("address granted on a failed request");

   a_unit_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_bytes[UNIT_SHIFT-1:0] == '0)
      else $error("free byte count not a whole number of units");

endmodule

bind next_fit_heap_allocator_top nfha_checker u_nfha_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_status          (rsp_status),
   .rsp_granted_address (rsp_granted_address),
   .rsp_free_bytes      (rsp_free_bytes)
);

@@ sim/next_fit_heap_allocator_top_test.sv @@
// Testbench for the next-fit heap allocator: directed table, random phases, free-list predictor.
`timescale 1ns / 1ps

module next_fit_heap_allocator_top_test;
   import nfha_pkg::*;

   localparam int STORE_UNITS = 4096;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   granted;
      logic [FREE_W-1:0]   free_bytes;
   } alloc_result_type;

   typedef struct {
      logic                kind;
      logic [BYTES_W-1:0]  bytes;
      logic [ADDR_W-1:0]   addr;
      bit                  pop_live;
      bit                  typed;
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   granted;
      logic [FREE_W-1:0]   free_bytes;
   } table_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_kind = KIND_ALLOC;
   logic [BYTES_W-1:0]  req_request_bytes = '0;
   logic [ADDR_W-1:0]   req_block_address = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_granted_address;
   logic [FREE_W-1:0]   rsp_free_bytes;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [2:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   next_fit_heap_allocator_top #(.HEAP_UNITS(STORE_UNITS)) dut (.*);

   always #5 clock = ~clock;

   // predictor state
   int unsigned   hdr_size [STORE_UNITS];
   int unsigned   hdr_next [STORE_UNITS];
   int unsigned   cfg_base = 0;
   int unsigned   cfg_units = 4096;
   int unsigned   rover = 0;
   bit            started = 0;
   bit            list_empty = 0;
   int unsigned   free_units = 0;

   alloc_result_type pending_q [$];
   logic [ADDR_W-1:0] live_q [$];
   int            errors = 0;
   int            tx_idle_pct = 0;
   int            rx_idle_pct = 0;
   int            hold_left = 0;

   function automatic int unsigned eff_units();
      return (cfg_units > STORE_UNITS) ? STORE_UNITS : cfg_units;
   endfunction

   function automatic void add_free_units(int unsigned n);
      int unsigned s;
      s = free_units + n;
      if (s > eff_units()) s = eff_units();
      free_units = s;
   endfunction

   function automatic logic [STATUS_W-1:0] alloc_units(int unsigned bytes,
                                                       output logic [ADDR_W-1:0] granted);
      int unsigned need, prev, p, sz, blk;
      need = (bytes + 15) / 16 + 1;
      granted = '0;
      if (!started) begin
         rover = 0;
         hdr_size[0] = eff_units();
         hdr_next[0] = 0;
         free_units = eff_units();
         started = 1;
         list_empty = (eff_units() == 0);
      end
      if (list_empty) return STATUS_NO_FIT;
      prev = rover;
      p = hdr_next[prev] % STORE_UNITS;
      for (int steps = 0; steps <= STORE_UNITS; steps++) begin
         sz = hdr_size[p];
         if (sz >= need) begin
            blk = p;
            if (sz == need) begin
               hdr_next[prev] = hdr_next[p];
               if (p == prev) list_empty = 1;
            end else begin
               hdr_size[p] = sz - need;
               blk = (p + sz - need) % STORE_UNITS;
               hdr_size[blk] = need;
            end
            rover = prev;
            free_units = (free_units >= need) ? free_units - need : 0;
            granted = ADDR_W'(cfg_base + blk + 1);
            return STATUS_OK;
         end
         if (p == rover) return STATUS_NO_FIT;
         prev = p;
         p = hdr_next[p] % STORE_UNITS;
      end
      return STATUS_NO_FIT;
   endfunction

   function automatic int unsigned unit_of(logic [ADDR_W-1:0] addr);
      return (addr - cfg_base - 1) & 16'hFFFF;
   endfunction

   function automatic logic [STATUS_W-1:0] free_units_at(logic [ADDR_W-1:0] addr);
      int unsigned bp, p, nx, up;
      bit found;
      found = 0;
      if (!started) return STATUS_NO_HEAP;
      bp = unit_of(addr);
      if (bp >= eff_units()) return STATUS_OK;
      if (list_empty) begin
         hdr_next[bp] = bp;
         rover = bp;
         list_empty = 0;
         add_free_units(hdr_size[bp]);
         return STATUS_OK;
      end
      p = rover;
      for (int steps = 0; steps <= STORE_UNITS; steps++) begin
         nx = hdr_next[p];
         if (bp > p && bp < nx) begin found = 1; break; end
         if (p >= nx && (bp > p || bp < nx)) begin found = 1; break; end
         p = nx % STORE_UNITS;
      end
      if (!found) return STATUS_OK;
      add_free_units(hdr_size[bp]);
      up = hdr_next[p] % STORE_UNITS;
      if (bp + hdr_size[bp] == up) begin
         hdr_size[bp] += hdr_size[up];
         hdr_next[bp] = hdr_next[up];
      end else begin
         hdr_next[bp] = up;
      end
      if (p + hdr_size[p] == bp) begin
         hdr_size[p] += hdr_size[bp];
         hdr_next[p] = hdr_next[bp];
      end else begin
         hdr_next[p] = bp;
      end
      rover = p;
      return STATUS_OK;
   endfunction

   function automatic alloc_result_type predict(logic kind, logic [BYTES_W-1:0] bytes,
                                                logic [ADDR_W-1:0] addr);
      alloc_result_type r;
      if (kind == KIND_ALLOC) begin
         r.status = alloc_units(bytes, r.granted);
         if (r.status == STATUS_OK) live_q.push_back(r.granted);
      end else begin
         r.status = free_units_at(addr);
         r.granted = '0;
      end
      r.free_bytes = FREE_W'(free_units * 16);
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      alloc_result_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_q.size() == 0) begin
               report("unexpected word", rsp_status, 0);
            end else begin
               e = pending_q.pop_front();
               if (rsp_status !== e.status) report("status", rsp_status, e.status);
               if (rsp_granted_address !== e.granted)
                  report("granted_address", rsp_granted_address, e.granted);
               if (rsp_free_bytes !== e.free_bytes)
                  report("free_bytes", rsp_free_bytes, e.free_bytes);
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic send(logic kind, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] addr,
                       bit typed, alloc_result_type want);
      alloc_result_type r;
      bit ok;
      r = predict(kind, bytes, addr);
      pending_q.push_back(typed ? want : r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_request_bytes <= bytes;
      req_block_address <= addr;
      do begin
         @(negedge clock);
         ok = req_ready;
         @(posedge clock);
      end while (!ok);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_sel, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_sel == REG_HEAP_BASE) cfg_base = value & 32'hFFFF;
      else cfg_units = value & 32'h1FFF;
      started = 0;
      list_empty = 0;
      free_units = 0;
      live_q.delete();
   endtask

   table_row_type rows [] = '{
      '{KIND_FREE,  20'd0, 16'd5, 0, 1, STATUS_NO_HEAP, 16'd0, 17'd0},
      '{KIND_ALLOC, 20'd0, 16'd0, 0, 1, STATUS_OK, 16'd4096, 17'd65520},
      '{KIND_ALLOC, 20'hFFFFF, 16'd0, 0, 1, STATUS_NO_FIT, 16'd0, 17'd65520},
      '{KIND_FREE,  20'd0, 16'd1, 0, 1, STATUS_OK, 16'd0, 17'd65520},
      '{KIND_FREE,  20'd0, 16'd0, 0, 1, STATUS_OK, 16'd0, 17'd65520},
      '{KIND_FREE,  20'd0, 16'hFFFF, 0, 0, '0, '0, '0},
      '{KIND_ALLOC, 20'd16, 16'd0, 0, 0, '0, '0, '0},
      '{KIND_ALLOC, 20'd17, 16'd0, 0, 0, '0, '0, '0},
      '{KIND_ALLOC, 20'd100, 16'd0, 0, 0, '0, '0, '0},
      '{KIND_FREE,  20'd0, 16'd0, 1, 0, '0, '0, '0},
      '{KIND_ALLOC, 20'd1, 16'd0, 0, 0, '0, '0, '0},
      '{KIND_FREE,  20'd0, 16'd0, 1, 0, '0, '0, '0},
      '{KIND_FREE,  20'd0, 16'd0, 1, 0, '0, '0, '0},
      '{KIND_ALLOC, 20'd65520, 16'd0, 0, 0, '0, '0, '0},
      '{KIND_ALLOC, 20'd65504, 16'd0, 0, 0, '0, '0, '0},
      '{KIND_FREE,  20'd0, 16'd0, 1, 0, '0, '0, '0},
      '{KIND_ALLOC, 20'd65504, 16'd0, 0, 0, '0, '0, '0},
      '{KIND_FREE,  20'd0, 16'd0, 1, 0, '0, '0, '0},
      '{KIND_FREE,  20'd0, 16'd0, 1, 0, '0, '0, '0}
   };

   int unsigned phase_base [7] = '{0, 16'hFFFF, 16'h8000, 16'h1234, 16'hFFF0, 16'h0F0F, 16'h7001};
   int unsigned phase_units [7] = '{4096, 2, 1, 0, 8191, 64, 300};

   initial begin
      alloc_result_type want;
      logic [ADDR_W-1:0] a;
      int unsigned lim, pick, roll;
      bit got;
      for (int i = 0; i < STORE_UNITS; i++) begin
         hdr_size[i] = 0;
         hdr_next[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         a = rows[i].addr;
         if (rows[i].pop_live && live_q.size() != 0) a = live_q.pop_back();
         want = '{rows[i].status, rows[i].granted, rows[i].free_bytes};
         send(rows[i].kind, rows[i].bytes, a, rows[i].typed, want);
      end
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         csr_write(REG_HEAP_BASE, (ph == 5) ? $urandom() : phase_base[ph]);
         csr_write(REG_HEAP_UNITS, (ph == 5) ? $urandom_range(2, 400) : phase_units[ph]);
         if (ph < 2) begin
            tx_idle_pct = 6;
            rx_idle_pct = 75;
         end else if (ph < 4) begin
            tx_idle_pct = 75;
            rx_idle_pct = 6;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         if (ph == 4) hold_left = 400;
         lim = (eff_units() < 2) ? 64 : eff_units() * 4;
         for (int n = 0; n < 90; n++) begin
            roll = $urandom_range(99);
            if (roll < 35 && live_q.size() != 0) begin
               pick = $urandom_range(live_q.size() - 1);
               a = live_q[pick];
               live_q.delete(pick);
               send(KIND_FREE, BYTES_W'($urandom()), a, 0, want);
            end else if (roll < 45) begin
               got = 0;
               for (int t = 0; t < 20 && !got; t++) begin
                  a = ADDR_W'($urandom());
                  got = (unit_of(a) >= eff_units());
               end
               if (got) send(KIND_FREE, BYTES_W'($urandom()), a, 0, want);
               else send(KIND_ALLOC, BYTES_W'($urandom_range(lim)), ADDR_W'($urandom()), 0,
                         want);
            end else if (roll < 52) begin
               send(KIND_ALLOC, BYTES_W'($urandom()), ADDR_W'($urandom()), 0, want);
            end else begin
               send(KIND_ALLOC, BYTES_W'($urandom_range(lim)), ADDR_W'($urandom()), 0, want);
            end
         end
         drain();
      end

      if (errors == 0 && pending_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("simulation failed");
      $finish;
   end

endmodule
